// ===== hw/rtl/contiguous_region_allocator_defines.svh =====
// Assertion macros for the region allocator RTL.
`ifndef CONTIGUOUS_REGION_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_REGION_ALLOCATOR_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define CRA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define CRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cra_pkg.sv =====
// Types and constants of the contiguous region allocator.
package cra_pkg;

  localparam int unsigned MaxRegionsDef = 16;
  localparam int unsigned AddrBitsDef   = 20;
  localparam int unsigned MemSizeW      = 21;
  localparam int unsigned OwnerW        = 16;
  localparam logic [MemSizeW-1:0] MemSizeReset = 21'd1048576;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_COMPACT = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_OTHER = 2'd3
  } strategy_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_NOFIT   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NOOWNER = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_RELEASE,
    ST_COMPACT,
    ST_DONE
  } state_e;

endpackage

// ===== hw/rtl/cra_cell.sv =====
// One table cell: owner, first and last address of one region slot.
module cra_cell #(
  parameter int unsigned ADDR_BITS = cra_pkg::AddrBitsDef
) (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic [cra_pkg::OwnerW-1:0] owner_i,
  input  logic [ADDR_BITS-1:0]       first_i,
  input  logic [ADDR_BITS-1:0]       last_i,
  output logic [cra_pkg::OwnerW-1:0] owner_o,
  output logic [ADDR_BITS-1:0]       first_o,
  output logic [ADDR_BITS-1:0]       last_o
);
  import cra_pkg::*;

  logic [OwnerW-1:0]    owner_q;
  logic [ADDR_BITS-1:0] first_q;
  logic [ADDR_BITS-1:0] last_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      owner_q <= owner_i;
      first_q <= first_i;
      last_q  <= last_i;
    end
  end

  assign owner_o = owner_q;
  assign first_o = first_q;
  assign last_o  = last_q;

endmodule

// ===== hw/rtl/contiguous_region_allocator.sv =====
// Contiguous region allocator: top level with control and the cell ring.
// The region table lives in a ring of MAX_REGIONS cells that rotates by one
// entry per cycle during a pass, so the controller sees entry j at the head
// cell in step j of a pass and writes the entry back at the tail. An
// allocation that finds a hole takes one scan pass to choose the hole and one
// rewrite pass to insert the region. A refused allocation, a release or a
// compact is a single pass; an allocation into a full table and an unknown
// command go to the result with no pass. One transaction is worked on at a
// time; the next one is accepted while the previous result still waits in
// the output register.
module contiguous_region_allocator #(
  parameter int unsigned MAX_REGIONS = cra_pkg::MaxRegionsDef,
  parameter int unsigned ADDR_BITS   = cra_pkg::AddrBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cra_pkg::MemSizeW-1:0] memory_size_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  cra_pkg::cmd_e                cmd_i,
  input  logic [cra_pkg::OwnerW-1:0]   owner_id_i,
  input  logic [cra_pkg::MemSizeW-1:0] request_size_i,
  input  cra_pkg::strategy_e           strategy_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output cra_pkg::status_e             status_o,
  output logic [ADDR_BITS-1:0]         region_start_o,
  output logic [ADDR_BITS-1:0]         region_end_o
);
  import cra_pkg::*;

  `include "contiguous_region_allocator_defines.svh"

  localparam int unsigned IW = $clog2(MAX_REGIONS);
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned LW = (ADDR_BITS + 1 > MemSizeW) ? ADDR_BITS + 1 : MemSizeW;

  // Cell ring.
  logic [OwnerW-1:0]    cell_owner [MAX_REGIONS];
  logic [ADDR_BITS-1:0] cell_first [MAX_REGIONS];
  logic [ADDR_BITS-1:0] cell_last  [MAX_REGIONS];
  logic                 shift;
  logic [OwnerW-1:0]    tail_owner;
  logic [ADDR_BITS-1:0] tail_first;
  logic [ADDR_BITS-1:0] tail_last;

  for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
    if (k == MAX_REGIONS - 1) begin : g_tail
      cra_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
        .clk_i, .shift_i(shift),
        .owner_i(tail_owner), .first_i(tail_first), .last_i(tail_last),
        .owner_o(cell_owner[k]), .first_o(cell_first[k]), .last_o(cell_last[k])
      );
    end else begin : g_body
      cra_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
        .clk_i, .shift_i(shift),
        .owner_i(cell_owner[k+1]), .first_i(cell_first[k+1]), .last_i(cell_last[k+1]),
        .owner_o(cell_owner[k]), .first_o(cell_first[k]), .last_o(cell_last[k])
      );
    end
  end

  // Control and working registers.
  state_e               state_q, state_d;
  logic [IW-1:0]        step_q, step_d;
  logic [CW-1:0]        count_q, count_d;
  logic [MemSizeW-1:0]  mem_size_q;
  logic [OwnerW-1:0]    owner_q, owner_d;
  logic [MemSizeW-1:0]  size_q, size_d;
  strategy_e            strat_q, strat_d;
  logic                 found_q, found_d;
  logic [LW-1:0]        prev_end_q, prev_end_d;
  logic [LW-1:0]        best_len_q, best_len_d;
  logic [LW-1:0]        best_start_q, best_start_d;
  logic [IW-1:0]        pick_q, pick_d;
  logic [OwnerW-1:0]    hold_owner_q;
  logic [ADDR_BITS-1:0] hold_first_q, hold_last_q;
  logic [ADDR_BITS-1:0] next_q, next_d;
  status_e              res_status_q, res_status_d;
  logic [ADDR_BITS-1:0] res_start_q, res_start_d, res_end_q, res_end_d;
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q;
  logic [ADDR_BITS-1:0] out_start_q, out_end_q;

  logic                 in_fire, last_step, in_table, out_free, take, fit;
  logic [LW-1:0]        mem_ext, cap, usable, hi, len, new_last_ext;
  logic [ADDR_BITS-1:0] span;

  assign in_fire   = in_valid_i && in_ready_o;
  assign last_step = (step_q == IW'(MAX_REGIONS - 1));
  assign in_table  = (CW'(step_q) < count_q);
  assign out_free  = !out_valid_q || out_ready_i;

  assign mem_ext = LW'(mem_size_q);
  assign cap     = LW'(1) << ADDR_BITS;
  assign usable  = (mem_ext < cap) ? mem_ext : cap;

  // Hole ending just before head entry, or the trailing hole once past the table.
  assign hi  = in_table ? LW'(cell_first[0]) : usable;
  assign len = (hi > prev_end_q) ? hi - prev_end_q : '0;
  assign fit = (CW'(step_q) <= count_q) && (len >= LW'(size_q)) && (size_q != '0);
  assign take = fit && (!found_q ||
                        (strat_q == FIT_BEST  && len < best_len_q) ||
                        (strat_q == FIT_WORST && len > best_len_q));

  assign new_last_ext = best_start_q + LW'(size_q) - LW'(1);
  assign span         = cell_last[0] - cell_first[0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd_i)
            CMD_ALLOC:   state_d = (count_q == CW'(MAX_REGIONS)) ? ST_DONE : ST_SCAN;
            CMD_RELEASE: state_d = ST_RELEASE;
            CMD_COMPACT: state_d = ST_COMPACT;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (last_step) begin
          state_d = (found_q || take) ? ST_INSERT : ST_DONE;
        end
      end
      ST_INSERT, ST_RELEASE, ST_COMPACT: begin
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    step_d       = step_q;
    count_d      = count_q;
    owner_d      = owner_q;
    size_d       = size_q;
    strat_d      = strat_q;
    found_d      = found_q;
    prev_end_d   = prev_end_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    pick_d       = pick_q;
    next_d       = next_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    res_end_d    = res_end_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    shift        = 1'b0;
    tail_owner   = cell_owner[0];
    tail_first   = cell_first[0];
    tail_last    = cell_last[0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          owner_d      = owner_id_i;
          size_d       = request_size_i;
          strat_d      = strategy_i;
          found_d      = 1'b0;
          prev_end_d   = '0;
          best_len_d   = '0;
          best_start_d = '0;
          next_d       = '0;
          step_d       = '0;
          res_start_d  = '0;
          res_end_d    = '0;
          res_status_d = STAT_DONE;
          if (cmd_i == CMD_ALLOC && count_q == CW'(MAX_REGIONS)) begin
            res_status_d = STAT_FULL;
          end
        end
      end
      ST_SCAN: begin
        shift  = 1'b1;
        step_d = last_step ? '0 : step_q + IW'(1);
        if (in_table) begin
          prev_end_d = LW'(cell_last[0]) + LW'(1);
        end
        if (take) begin
          found_d      = 1'b1;
          best_len_d   = len;
          best_start_d = prev_end_q;
          pick_d       = step_q;
        end
        if (last_step && !(found_q || take)) begin
          res_status_d = STAT_NOFIT;
        end
      end
      ST_INSERT: begin
        // Entries after the new one reach the tail through the hold register.
        shift  = 1'b1;
        step_d = last_step ? '0 : step_q + IW'(1);
        if (step_q == pick_q) begin
          tail_owner = owner_q;
          tail_first = best_start_q[ADDR_BITS-1:0];
          tail_last  = new_last_ext[ADDR_BITS-1:0];
        end else if (step_q > pick_q) begin
          tail_owner = hold_owner_q;
          tail_first = hold_first_q;
          tail_last  = hold_last_q;
        end
        if (last_step) begin
          count_d     = count_q + CW'(1);
          res_start_d = best_start_q[ADDR_BITS-1:0];
          res_end_d   = new_last_ext[ADDR_BITS-1:0];
        end
      end
      ST_RELEASE: begin
        // From the first match on, each slot takes its successor's entry.
        shift  = 1'b1;
        step_d = last_step ? '0 : step_q + IW'(1);
        if (in_table && cell_owner[0] == owner_q) begin
          found_d = 1'b1;
        end
        if (found_d) begin
          tail_owner = cell_owner[1];
          tail_first = cell_first[1];
          tail_last  = cell_last[1];
        end
        if (last_step) begin
          if (found_d) begin
            count_d = count_q - CW'(1);
          end else begin
            res_status_d = STAT_NOOWNER;
          end
        end
      end
      ST_COMPACT: begin
        shift  = 1'b1;
        step_d = last_step ? '0 : step_q + IW'(1);
        if (in_table) begin
          tail_first = next_q;
          tail_last  = next_q + span;
          next_d     = next_q + span + ADDR_BITS'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      mem_size_q  <= MemSizeReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mem_size_q <= memory_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    owner_q      <= owner_d;
    size_q       <= size_d;
    strat_q      <= strat_d;
    found_q      <= found_d;
    prev_end_q   <= prev_end_d;
    best_len_q   <= best_len_d;
    best_start_q <= best_start_d;
    pick_q       <= pick_d;
    next_q       <= next_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    res_end_q    <= res_end_d;
    hold_owner_q <= cell_owner[0];
    hold_first_q <= cell_first[0];
    hold_last_q  <= cell_last[0];
    if (state_q == ST_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_start_q  <= res_start_q;
      out_end_q    <= res_end_q;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign region_start_o = out_start_q;
  assign region_end_o   = out_end_q;

  `CRA_ASSERT(count_in_range, count_q <= CW'(MAX_REGIONS), "region count above table size")
  `CRA_ASSERT_IMP(pick_in_table, state_q == ST_INSERT, CW'(pick_q) <= count_q,
                  "insert position beyond table end")
  `CRA_ASSERT_IMP(step_zero_idle, state_q == ST_IDLE || state_q == ST_DONE, step_q == '0,
                  "pass counter not parked outside a pass")
  `CRA_ASSERT_NEXT(busy_after_accept, in_fire, state_q != ST_IDLE,
                   "controller idle right after a transaction was accepted")

endmodule
